// ===== rtl/core/rpa_pkg.sv =====
// Shared types, constants and codes for the refcounted page allocator.
`timescale 1ns / 1ps

package rpa_pkg;

    localparam int PAGE_W    = 15;
    localparam int NUM_PAGES = 1 << PAGE_W;
    localparam int TOP_W     = PAGE_W + 1;
    localparam int COUNT_W   = 16;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // request opcodes as they arrive on the item channel
    localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE   = 3'd2;
    localparam logic [OP_W-1:0] OP_ADDREF = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNREF = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER  = 3'd4;

    // classified request kinds handed from front to back
    typedef logic [2:0] kind_t;
    localparam kind_t K_NOP    = 3'd0;
    localparam kind_t K_INIT   = 3'd1;
    localparam kind_t K_ALLOC  = 3'd2;
    localparam kind_t K_FREE   = 3'd3;
    localparam kind_t K_ADDREF = 3'd4;
    localparam kind_t K_READ   = 3'd5;

    typedef struct packed {
        kind_t             kind;
        logic [PAGE_W-1:0] page;
        logic              range_err;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page_out;
        logic [COUNT_W-1:0]  ref_count;
        logic [TOP_W-1:0]    free_count;
        logic [TOP_W-1:0]    total_pages;
    } result_t;

endpackage

// ===== rtl/core/rpa_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module rpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rpa_front.sv =====
// Request front end: accepts beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module rpa_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [rpa_pkg::OP_W-1:0]  op,
    input  logic [rpa_pkg::PAGE_W-1:0] page,
    input  logic [rpa_pkg::PAGE_W-1:0] first_usable_page,
    output rpa_pkg::queue_head_t      head,
    input  rpa_pkg::back_ctl_t        ctl
);
    import rpa_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    item_t             classified;
    logic              push;
    logic              pop;

    always_comb
    begin
        classified.page      = page;
        classified.range_err = page < first_usable_page;
        unique case (op)
            OP_INIT:   classified.kind = K_INIT;
            OP_ALLOC:  classified.kind = K_ALLOC;
            OP_FREE:   classified.kind = K_FREE;
            OP_ADDREF: classified.kind = K_ADDREF;
            OP_READ:   classified.kind = K_READ;
            default:   classified.kind = K_NOP;
        endcase
    end

    // no beats while the queue is full or while the count memory is being cleared after reset
    assign item_stall = (count_reg == CNT_W'(QUEUE_DEPTH)) || ctl.clearing;
    assign push       = item_valid && !item_stall;
    assign pop        = ctl.pop && (count_reg != '0);

    assign head.valid = count_reg != '0;
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ===== rtl/core/rpa_back.sv =====
// Execution back end: free stack, reference counts, init sweep and result register.
`timescale 1ns / 1ps

module rpa_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rpa_pkg::PAGE_W-1:0]  first_usable_page,
    input  rpa_pkg::queue_head_t        head,
    output rpa_pkg::back_ctl_t          ctl,
    output logic                        result_valid,
    input  logic                        result_stall,
    output rpa_pkg::result_t            result
);
    import rpa_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;
    localparam logic [1:0] S_REF   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [PAGE_W-1:0] sweep_reg, sweep_next;
    logic              push_reg, push_next;
    logic [TOP_W-1:0]  top_reg, top_next;
    logic [TOP_W-1:0]  pool_reg, pool_next;
    item_t             cur_reg, cur_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;

    logic [TOP_W-1:0]  top_dec;
    logic [TOP_W-1:0]  range_size;
    logic              can_go;
    logic              emit;
    logic              pop;

    logic                ref_we, ref_re;
    logic [PAGE_W-1:0]   ref_waddr, ref_raddr;
    logic [COUNT_W-1:0]  ref_wdata, ref_rdata, cnt_dec, cnt_inc;
    logic                stk_we, stk_re;
    logic [PAGE_W-1:0]   stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    rpa_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_PAGES)) u_refs (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .re    (ref_re),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    rpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign top_dec    = top_reg - 1'b1;
    assign range_size = TOP_W'(NUM_PAGES) - TOP_W'(first_usable_page);
    assign cnt_dec    = ref_rdata - 1'b1;
    assign cnt_inc    = ref_rdata + 1'b1;
    // a new item may start only if its result has a free slot
    assign can_go     = !res_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        push_next  = push_reg;
        top_next   = top_reg;
        pool_next  = pool_reg;
        cur_next   = cur_reg;
        emit       = 1'b0;
        pop        = 1'b0;
        res_next   = res_reg;

        ref_we    = 1'b0;
        ref_waddr = cur_reg.page;
        ref_wdata = '0;
        ref_re    = 1'b0;
        ref_raddr = head.item.page;
        stk_we    = 1'b0;
        stk_waddr = top_reg[PAGE_W-1:0];
        stk_wdata = cur_reg.page;
        stk_re    = 1'b0;
        stk_raddr = top_dec[PAGE_W-1:0];

        res_next.status    = ST_OK;
        res_next.page_out  = cur_reg.page;
        res_next.ref_count = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid && can_go)
                begin
                    pop               = 1'b1;
                    cur_next          = head.item;
                    res_next.page_out = head.item.page;
                    unique case (head.item.kind)
                        K_INIT:
                        begin
                            sweep_next = '0;
                            push_next  = 1'b1;
                            state_next = S_SWEEP;
                        end
                        K_ALLOC:
                        begin
                            if (top_reg == '0)
                            begin
                                emit              = 1'b1;
                                res_next.status   = ST_EMPTY;
                                res_next.page_out = '0;
                            end
                            else
                            begin
                                stk_re     = 1'b1;
                                top_next   = top_dec;
                                state_next = S_ALLOC;
                            end
                        end
                        K_FREE, K_ADDREF, K_READ:
                        begin
                            if (head.item.range_err)
                            begin
                                emit            = 1'b1;
                                res_next.status = ST_RANGE;
                            end
                            else
                            begin
                                ref_re     = 1'b1;
                                state_next = S_REF;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                // one count entry cleared per cycle; init stacks usable pages
                ref_we    = 1'b1;
                ref_waddr = sweep_reg;
                ref_wdata = '0;
                if (push_reg && (sweep_reg >= first_usable_page))
                begin
                    stk_we    = 1'b1;
                    stk_waddr = sweep_reg - first_usable_page;
                    stk_wdata = sweep_reg;
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '1)
                begin
                    state_next = S_IDLE;
                    if (push_reg)
                    begin
                        top_next  = range_size;
                        pool_next = range_size;
                        emit      = 1'b1;
                    end
                end
            end
            S_ALLOC:
            begin
                ref_we             = 1'b1;
                ref_waddr          = stk_rdata;
                ref_wdata          = COUNT_W'(1);
                emit               = 1'b1;
                res_next.page_out  = stk_rdata;
                res_next.ref_count = COUNT_W'(1);
                state_next         = S_IDLE;
            end
            S_REF:
            begin
                emit       = 1'b1;
                state_next = S_IDLE;
                unique case (cur_reg.kind)
                    K_FREE:
                    begin
                        if (ref_rdata == '0)
                        begin
                            res_next.status = ST_UNREF;
                        end
                        else
                        begin
                            ref_we             = 1'b1;
                            ref_wdata          = cnt_dec;
                            res_next.ref_count = cnt_dec;
                            // push on last release, dropped if the stack is full
                            if ((cnt_dec == '0) && (top_reg < TOP_W'(NUM_PAGES)))
                            begin
                                stk_we   = 1'b1;
                                top_next = top_reg + 1'b1;
                            end
                        end
                    end
                    K_ADDREF:
                    begin
                        if (ref_rdata == COUNT_MAX)
                        begin
                            res_next.status    = ST_OVER;
                            res_next.ref_count = ref_rdata;
                        end
                        else
                        begin
                            ref_we             = 1'b1;
                            ref_wdata          = cnt_inc;
                            res_next.ref_count = cnt_inc;
                        end
                    end
                    default:
                    begin
                        res_next.ref_count = ref_rdata;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_next.free_count  = top_next;
        res_next.total_pages = pool_next;

        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset starts with a clearing sweep of the count memory
            state_reg     <= S_SWEEP;
            sweep_reg     <= '0;
            push_reg      <= 1'b0;
            top_reg       <= '0;
            pool_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            push_reg      <= push_next;
            top_reg       <= top_next;
            pool_reg      <= pool_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    assign ctl.pop      = pop;
    assign ctl.clearing = (state_reg == S_SWEEP) && !push_reg;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== rtl/core/refcounted_page_allocator_top.sv =====
// Top level of the refcounted page allocator: config register, front end and back end.
`timescale 1ns / 1ps

// Refcounted page allocator. Manages pages 0..32767 with a LIFO free stack and a
// 16-bit reference count per page, both held in block RAM (32768 entries each).
// Requests arrive as beats on the item channel (op, page) and each produces exactly
// one result beat (status, page_out, ref_count, free_count, total_pages), in order.
// A small front-end queue classifies requests (opcode decode, range check against
// first_usable_page) so the item channel keeps moving while the back end works.
// Alloc, free, add-reference and read-count do one registered RAM read in the back end,
// then any write-back and result; out-of-range, empty pool and unknown opcodes are
// answered at dispatch. Init walks the whole count RAM, clearing one entry per cycle
// and filling one stack slot for each page from first_usable_page up, with the result
// registered on the last sweep cycle. After reset the back end runs the same walk to
// clear the counts, without filling the free stack or emitting a result beat;
// item_stall is held high until it finishes. APB writes are taken at any time but
// first_usable_page must only be changed while the block is idle.
module refcounted_page_allocator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [1:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [rpa_pkg::OP_W-1:0]       op,
    input  logic [rpa_pkg::PAGE_W-1:0]     page,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [rpa_pkg::STATUS_W-1:0]   status,
    output logic [rpa_pkg::PAGE_W-1:0]     page_out,
    output logic [rpa_pkg::COUNT_W-1:0]    ref_count,
    output logic [rpa_pkg::TOP_W-1:0]      free_count,
    output logic [rpa_pkg::TOP_W-1:0]      total_pages
);
    import rpa_pkg::*;

    localparam logic [1:0] ADDR_FIRST_USABLE = 2'd0;

    logic [PAGE_W-1:0] first_usable_reg, first_usable_next;
    logic              cfg_write;
    queue_head_t       head;
    back_ctl_t         ctl;
    result_t           result;

    // APB: zero wait states, single register at byte 0
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_FIRST_USABLE);
    assign prdata    = (paddr == ADDR_FIRST_USABLE) ? {{(32 - PAGE_W){1'b0}}, first_usable_reg}
                                                    : 32'd0;

    always_comb
    begin
        first_usable_next = cfg_write ? pwdata[PAGE_W-1:0] : first_usable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_usable_reg <= '0;
        end
        else
        begin
            first_usable_reg <= first_usable_next;
        end
    end

    rpa_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .op                (op),
        .page              (page),
        .first_usable_page (first_usable_reg),
        .head              (head),
        .ctl               (ctl)
    );

    rpa_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .first_usable_page (first_usable_reg),
        .head              (head),
        .ctl               (ctl),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result            (result)
    );

    assign status      = result.status;
    assign page_out    = result.page_out;
    assign ref_count   = result.ref_count;
    assign free_count  = result.free_count;
    assign total_pages = result.total_pages;

endmodule

// ===== rtl/core/rpa_checker.sv =====
// Port-level assertions for the refcounted page allocator, bound to the top level.
`timescale 1ns / 1ps

module rpa_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  logic [rpa_pkg::STATUS_W-1:0] status,
    input  logic [rpa_pkg::PAGE_W-1:0]   page_out,
    input  logic [rpa_pkg::COUNT_W-1:0]  ref_count,
    input  logic [rpa_pkg::TOP_W-1:0]    free_count,
    input  logic [rpa_pkg::TOP_W-1:0]    total_pages
);
    import rpa_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status)
            && $stable(page_out) && $stable(ref_count) && $stable(free_count)
            && $stable(total_pages))
        else $error("result beat changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == ST_OK) || (status == ST_RANGE) || (status == ST_UNREF)
            || (status == ST_EMPTY) || (status == ST_OVER))
        else $error("undefined status code");

    // empty pool means nothing popped and an empty stack
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_EMPTY) |-> (page_out == '0) && (ref_count == '0)
            && (free_count == '0))
        else $error("empty-pool result with nonzero fields");

    a_nocount: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((status == ST_RANGE) || (status == ST_UNREF)) |-> ref_count == '0)
        else $error("rejected request reports a count");

endmodule

bind refcounted_page_allocator_top rpa_checker u_rpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .page_out     (page_out),
    .ref_count    (ref_count),
    .free_count   (free_count),
    .total_pages  (total_pages)
);
